// ===== sv/trc_pkg.sv =====
// package for the tick rate converter
// constants and payload types, no dependencies
package trc_pkg;

  localparam int unsigned TickWidth = 64;
  localparam int unsigned RefRateWidth = 27;
  localparam logic [RefRateWidth-1:0] RefRateHz = RefRateWidth'(100000000);
  localparam logic [TickWidth-1:0] HostFreqReset = TickWidth'(100000000);
  localparam logic [TickWidth-1:0] ProdLimit = 64'hFFFF_FFFF_FFFF_FFFF / 64'd100000000;
  localparam int unsigned AddrWidth = 4;
  localparam logic [AddrWidth-1:0] AddrHostFreq = AddrWidth'(0);

  typedef struct packed {
    logic [TickWidth-1:0] tick_count;
  } in_item_t;

  typedef struct packed {
    logic [TickWidth-1:0] ref_count;
    logic                 ok;
  } out_item_t;

endpackage

// ===== sv/trc_stream_if.sv =====
// valid/ready stream interfaces for request and result items
// depends on trc_pkg
interface trc_in_if;
  import trc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TickWidth-1:0] tick_count;
  modport source (output valid, output tick_count, input ready);
  modport sink (input valid, input tick_count, output ready);
endinterface

interface trc_out_if;
  import trc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TickWidth-1:0] ref_count;
  logic                 ok;
  modport source (output valid, output ref_count, output ok, input ready);
  modport sink (input valid, input ref_count, input ok, output ready);
endinterface

// ===== sv/trc_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on trc_pkg
module trc_div_pipe
  import trc_pkg::*;
#(
  parameter int unsigned QW = TickWidth,
  parameter int unsigned SW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [TickWidth-1:0] divisor_i,
  input  logic                 valid_i,
  input  logic [TickWidth-1:0] rem_i,
  input  logic [QW-1:0]        bits_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic [QW-1:0]        quot_o,
  output logic [TickWidth-1:0] rem_o,
  output logic [SW-1:0]        side_o
);

  logic                 valid_q [QW];
  logic [TickWidth-1:0] rem_q   [QW];
  logic [QW-1:0]        bits_q  [QW];
  logic [QW-1:0]        quot_q  [QW];
  logic [SW-1:0]        side_q  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic                 in_valid;
    logic [TickWidth-1:0] in_rem;
    logic [QW-1:0]        in_bits;
    logic [QW-1:0]        in_quot;
    logic [SW-1:0]        in_side;
    logic [TickWidth:0]   trial;
    logic                 ge;
    logic [TickWidth:0]   diff;
    logic [TickWidth-1:0] rem_d;

    if (s == 0) begin : g_head
      assign in_valid = valid_i;
      assign in_rem   = rem_i;
      assign in_bits  = bits_i;
      assign in_quot  = '0;
      assign in_side  = side_i;
    end else begin : g_link
      assign in_valid = valid_q[s-1];
      assign in_rem   = rem_q[s-1];
      assign in_bits  = bits_q[s-1];
      assign in_quot  = quot_q[s-1];
      assign in_side  = side_q[s-1];
    end

    always_comb begin
      trial = {in_rem, in_bits[QW-1]};
      ge    = trial >= {1'b0, divisor_i};
      diff  = trial - {1'b0, divisor_i};
      rem_d = ge ? diff[TickWidth-1:0] : trial[TickWidth-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        bits_q[s] <= in_bits << 1;
        quot_q[s] <= {in_quot[QW-2:0], ge};
        side_q[s] <= in_side;
      end
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign rem_o   = rem_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== sv/trc_scale.sv =====
// two-stage scaling of whole seconds and leftover ticks by the reference rate
// depends on trc_pkg
module trc_scale
  import trc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [TickWidth-1:0] secs_i,
  input  logic [TickWidth-1:0] left_i,
  output logic                 valid_o,
  output logic [TickWidth-1:0] whole_o,
  output logic [TickWidth-1:0] lprod_o,
  output logic                 fail_o
);

  localparam int unsigned PW = 32 + RefRateWidth;

  logic          valid_q [2];
  logic [PW-1:0] s_lo_q, s_hi_q, l_lo_q, l_hi_q;
  logic          fail_q  [2];
  logic [TickWidth-1:0] whole_q, lprod_q;
  logic [TickWidth-1:0] whole_d, lprod_d;

  always_comb begin
    whole_d = TickWidth'(s_lo_q) + TickWidth'({s_hi_q, 32'd0});
    lprod_d = TickWidth'(l_lo_q) + TickWidth'({l_hi_q, 32'd0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
      valid_q[1] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      valid_q[1] <= valid_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_lo_q    <= PW'(secs_i[31:0]) * PW'(RefRateHz);
      s_hi_q    <= PW'(secs_i[63:32]) * PW'(RefRateHz);
      l_lo_q    <= PW'(left_i[31:0]) * PW'(RefRateHz);
      l_hi_q    <= PW'(left_i[63:32]) * PW'(RefRateHz);
      fail_q[0] <= (secs_i > ProdLimit) || (left_i > ProdLimit);
      whole_q   <= whole_d;
      lprod_q   <= lprod_d;
      fail_q[1] <= fail_q[0];
    end
  end

  assign valid_o = valid_q[1];
  assign whole_o = whole_q;
  assign lprod_o = lprod_q;
  assign fail_o  = fail_q[1];

endmodule

// ===== sv/tick_rate_converter_core.sv =====
// top level of the tick rate converter: apb register, divider and scaling pipeline
// depends on trc_pkg, trc_stream_if, trc_div_pipe, trc_scale
//
// Converts a 64-bit host tick count into a count at 100 MHz using the host frequency
// register (byte address 0, 64 bits, reset 100000000). A request is accepted every cycle
// unless a result is stalled; each result passes through the seconds divider, the
// scaling stages, the fraction divider and the output register. A stalled result holds
// the whole pipeline. A zero frequency or any overflow gives ok = 0 and ref_count = 0.
module tick_rate_converter_core
  import trc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [TickWidth-1:0] pwdata,
  output logic [TickWidth-1:0] prdata,
  output logic                 pready,
  trc_in_if.sink               req_i,
  trc_out_if.source            rsp_o
);

  logic [TickWidth-1:0] freq_q;
  logic                 en;

  logic                 d1_valid;
  logic [TickWidth-1:0] d1_quot, d1_rem;
  logic                 d1_side;

  logic                 sc_valid;
  logic [TickWidth-1:0] sc_whole, sc_lprod;
  logic                 sc_fail;

  logic                    d2_valid;
  logic [RefRateWidth-1:0] d2_quot;
  logic [TickWidth-1:0]    d2_rem;
  logic [TickWidth:0]      d2_side;

  logic [TickWidth:0]   sum;
  logic                 good;
  logic                 out_valid_q;
  out_item_t            out_q;

  assign pready = 1'b1;
  assign prdata = freq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= HostFreqReset;
    end else if (psel && penable && pwrite && paddr == AddrHostFreq) begin
      freq_q <= pwdata;
    end
  end

  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  trc_div_pipe #(.QW(TickWidth), .SW(1)) u_div_secs (
    .clk_i, .rst_ni, .en_i(en), .divisor_i(freq_q),
    .valid_i(req_i.valid), .rem_i('0), .bits_i(req_i.tick_count), .side_i(1'b0),
    .valid_o(d1_valid), .quot_o(d1_quot), .rem_o(d1_rem), .side_o(d1_side)
  );

  trc_scale u_scale (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d1_valid && !d1_side),
    .secs_i(d1_quot), .left_i(d1_rem),
    .valid_o(sc_valid), .whole_o(sc_whole), .lprod_o(sc_lprod), .fail_o(sc_fail)
  );

  trc_div_pipe #(.QW(RefRateWidth), .SW(TickWidth+1)) u_div_frac (
    .clk_i, .rst_ni, .en_i(en), .divisor_i(freq_q),
    .valid_i(sc_valid),
    .rem_i(TickWidth'(sc_lprod[TickWidth-1:RefRateWidth])),
    .bits_i(sc_lprod[RefRateWidth-1:0]),
    .side_i({sc_fail, sc_whole}),
    .valid_o(d2_valid), .quot_o(d2_quot), .rem_o(d2_rem), .side_o(d2_side)
  );

  always_comb begin
    sum  = {1'b0, d2_side[TickWidth-1:0]} + (TickWidth+1)'(d2_quot);
    good = !d2_side[TickWidth] && !sum[TickWidth] && (freq_q != '0) && (d2_rem < freq_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.ref_count <= good ? sum[TickWidth-1:0] : '0;
      out_q.ok        <= good;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.ref_count = out_q.ref_count;
  assign rsp_o.ok        = out_q.ok;

endmodule

// ===== bench/tb_top.sv =====
// testbench for tick_rate_converter_core: apb writes of the host frequency, random and
// directed tick requests, results checked against an in-bench conversion model
// depends on trc_pkg, trc_stream_if and the rtl
`timescale 1ns / 1ps

class tick_conv_scoreboard;
  trc_pkg::out_item_t pending_q[$];

  function trc_pkg::out_item_t convert(logic [63:0] ticks, logic [63:0] freq);
    trc_pkg::out_item_t r;
    logic [63:0] secs;
    logic [63:0] left;
    logic [63:0] whole;
    logic [127:0] frac;
    logic [64:0] total;
    r.ref_count = '0;
    r.ok = 1'b0;
    if (freq != 0) begin
      secs = ticks / freq;
      left = ticks % freq;
      if (secs <= trc_pkg::ProdLimit && left <= trc_pkg::ProdLimit) begin
        whole = secs * 64'd100000000;
        frac = ({64'd0, left} * 128'd100000000) / {64'd0, freq};
        total = {1'b0, whole} + {1'b0, frac[63:0]};
        if (!total[64]) begin
          r.ref_count = total[63:0];
          r.ok = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function void note_request(logic [63:0] ticks, logic [63:0] freq);
    pending_q = {pending_q, convert(ticks, freq)};
  endfunction

  function bit check_result(trc_pkg::out_item_t got, output string msg);
    trc_pkg::out_item_t want;
    msg = "";
    if (pending_q.size() == 0) begin
      msg = $sformatf("unexpected result %h ok %b", got.ref_count, got.ok);
      return 1'b0;
    end
    want = pending_q.pop_front();
    if (got.ref_count !== want.ref_count || got.ok !== want.ok) begin
      msg = $sformatf("result %h ok %b, want %h ok %b", got.ref_count, got.ok,
                      want.ref_count, want.ok);
      return 1'b0;
    end
    return 1'b1;
  endfunction
endclass

module tb_top;
  import trc_pkg::*;

  localparam int Latency = 94;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [TickWidth-1:0] pwdata = '0;
  logic [TickWidth-1:0] prdata;
  logic pready;
  logic [63:0] host_freq;
  bit calm;
  int hold_off;
  int mismatches;

  trc_in_if req_if ();
  trc_out_if rsp_if ();

  tick_conv_scoreboard sb;

  tick_rate_converter_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  task automatic write_freq(logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrHostFreq;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    host_freq = value;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_ticks(logic [63:0] ticks);
    while (!calm && $urandom_range(99) < 16) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.tick_count <= ticks;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(ticks, host_freq);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_ticks();
    case ($urandom_range(5))
      0: return rand64();
      1: return rand64() >> $urandom_range(63);
      2: return host_freq * $urandom_range(1000) + ($urandom_range(1) ? host_freq - 1 : 0);
      3: return 64'($urandom());
      default: return rand64() >> $urandom_range(40, 10);
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      rsp_if.ready <= 1'b0;
      hold_off--;
    end else begin
      rsp_if.ready <= calm || $urandom_range(99) >= 16;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      out_item_t got;
      string msg;
      got.ref_count = rsp_if.ref_count;
      got.ok = rsp_if.ok;
      if (!sb.check_result(got, msg)) report(msg);
    end
  end

  initial begin
    logic [63:0] freqs[7];
    sb = new();
    req_if.valid = 1'b0;
    req_if.tick_count = '0;
    rsp_if.ready = 1'b0;
    host_freq = HostFreqReset;
    freqs = '{64'd1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd19_200_000, 64'd3_000_000_000,
              64'd1_000_000_000_000, 64'd100_000_000};
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corners at reset frequency and at the extremes
    send_ticks(64'd0);
    send_ticks(64'hFFFF_FFFF_FFFF_FFFF);
    send_ticks(64'd99_999_999);
    send_ticks(ProdLimit * 64'd100_000_000);
    send_ticks(ProdLimit * 64'd100_000_000 + 64'd100_000_000);
    drain();
    write_freq(64'd0);
    send_ticks(64'd0);
    send_ticks(64'd12345);
    drain();
    write_freq(64'hFFFF_FFFF_FFFF_FFFF);
    send_ticks(64'hFFFF_FFFF_FFFF_FFFE);
    send_ticks(ProdLimit);
    send_ticks(ProdLimit + 1);
    send_ticks(64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    write_freq(64'd1);
    send_ticks(ProdLimit);
    send_ticks(ProdLimit + 1);
    drain();
    write_freq(ProdLimit + 64'd5);
    send_ticks(ProdLimit + 64'd3);
    send_ticks(64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    // random phases over several frequencies
    for (int ph = 0; ph < 10; ph++) begin
      write_freq(ph < 7 ? freqs[ph] : rand64() >> $urandom_range(63));
      calm = (ph == 3);
      if (ph == 5) hold_off = 400;
      for (int n = 0; n < 115; n++) send_ticks(rand_ticks());
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
